FILE: design/assert_macros.svh
// Assertion macros for the protection unit RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MPU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MPU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/cp15mpu_pkg.sv
// Package for the coprocessor register file and protection unit.
// Holds register codes, masks, ID constants, types and permission helpers.
package cp15mpu_pkg;

  // Region storage is sized for the largest configuration.
  localparam int REGION_MAX   = 8;
  localparam int REGION_IDX_W = 3;
  localparam int NUM_REGIONS_DEFAULT = 8;

  // Write masks and read-only ID values.
  localparam logic [31:0] CTRL_WRITE_MASK   = 32'h000F_F085;
  localparam logic [31:0] REGION_WRITE_MASK = 32'hFFFF_F03F;
  localparam logic [31:0] TCM_WRITE_MASK    = 32'hFFFF_F03E;
  localparam logic [31:0] LOCK_WRITE_MASK   = 32'h8000_0003;
  localparam logic [31:0] ID_MAIN           = 32'h4105_9461;
  localparam logic [31:0] ID_CACHE_TYPE     = 32'h0F0D_2112;
  localparam logic [31:0] ID_TCM_SIZE       = 32'h0014_0180;
  localparam logic [31:0] ALL_ONES          = 32'hFFFF_FFFF;
  localparam logic [31:0] REGION_BASE_MASK  = 32'hFFFF_F000;

  // Register codes.
  localparam logic [15:0] CODE_ID_MAIN0  = 16'h0000;
  localparam logic [15:0] CODE_ID_CACHE  = 16'h0001;
  localparam logic [15:0] CODE_ID_TCM    = 16'h0002;
  localparam logic [15:0] CODE_ID_MAIN3  = 16'h0003;
  localparam logic [15:0] CODE_ID_MAIN4  = 16'h0004;
  localparam logic [15:0] CODE_ID_MAIN5  = 16'h0005;
  localparam logic [15:0] CODE_ID_MAIN6  = 16'h0006;
  localparam logic [15:0] CODE_ID_MAIN7  = 16'h0007;
  localparam logic [15:0] CODE_CTRL      = 16'h0100;
  localparam logic [15:0] CODE_DCACHE    = 16'h0200;
  localparam logic [15:0] CODE_ICACHE    = 16'h0201;
  localparam logic [15:0] CODE_BUFFER    = 16'h0300;
  localparam logic [15:0] CODE_DPERM_OLD = 16'h0500;
  localparam logic [15:0] CODE_IPERM_OLD = 16'h0501;
  localparam logic [15:0] CODE_DPERM     = 16'h0502;
  localparam logic [15:0] CODE_IPERM     = 16'h0503;
  localparam logic [15:0] CODE_WFI_A     = 16'h0704;
  localparam logic [15:0] CODE_WFI_B     = 16'h0F82;
  localparam logic [15:0] CODE_CM_0      = 16'h0750;
  localparam logic [15:0] CODE_CM_1      = 16'h0751;
  localparam logic [15:0] CODE_CM_2      = 16'h0760;
  localparam logic [15:0] CODE_CM_3      = 16'h0761;
  localparam logic [15:0] CODE_CM_4      = 16'h07A1;
  localparam logic [15:0] CODE_CM_5      = 16'h07A4;
  localparam logic [15:0] CODE_CM_6      = 16'h07E1;
  localparam logic [15:0] CODE_DLOCK     = 16'h0900;
  localparam logic [15:0] CODE_ILOCK     = 16'h0901;
  localparam logic [15:0] CODE_DTCM      = 16'h0910;
  localparam logic [15:0] CODE_ITCM      = 16'h0911;
  localparam logic [15:0] CODE_PID_A     = 16'h0D01;
  localparam logic [15:0] CODE_PID_B     = 16'h0D11;
  localparam logic [7:0]  CODE_REGION_HI = 8'h06;

  // Permission nibble codes.
  localparam logic [3:0] PERM_PRIV_RW   = 4'd1;
  localparam logic [3:0] PERM_USER_RO   = 4'd2;
  localparam logic [3:0] PERM_FULL      = 4'd3;
  localparam logic [3:0] PERM_PRIV_RO   = 4'd5;
  localparam logic [3:0] PERM_ALL_RO    = 4'd6;

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_READ   = 2'd1,
    REQ_LOOKUP = 2'd2
  } req_type_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_HOLD
  } mpu_state_t;

  // Lookup token that travels along the region cells.
  typedef struct packed {
    logic                    valid;
    logic                    user;
    logic [31:0]             addr;
    logic                    hit;
    logic [REGION_IDX_W-1:0] idx;
  } lookup_tok_t;

  // One result beat.
  typedef struct packed {
    logic [31:0] read_data;
    logic        allow_read;
    logic        allow_write;
    logic        allow_exec;
    logic        data_cacheable;
    logic        instr_cacheable;
    logic        bufferable;
    logic        halt_request;
    logic        refused;
  } mpu_result_t;

  // Spread 2-bit legacy permissions into the low bits of each nibble.
  function automatic logic [31:0] widen_pairs(input logic [31:0] v);
    logic [31:0] r;
    r = '0;
    for (int k = 0; k < 8; k++) begin
      r[4*k +: 2] = v[2*k +: 2];
    end
    return r;
  endfunction

  // Collect the low two bits of each nibble.
  function automatic logic [31:0] narrow_nibbles(input logic [31:0] v);
    logic [31:0] r;
    r = '0;
    for (int k = 0; k < 8; k++) begin
      r[2*k +: 2] = v[4*k +: 2];
    end
    return r;
  endfunction

  // Data permission: returns {read, write}.
  function automatic logic [1:0] data_perm(input logic [3:0] p, input logic user);
    logic [1:0] rw;
    rw = 2'b00;
    case (p)
      PERM_PRIV_RW: rw = user ? 2'b00 : 2'b11;
      PERM_USER_RO: rw = user ? 2'b10 : 2'b11;
      PERM_FULL:    rw = 2'b11;
      PERM_PRIV_RO: rw = user ? 2'b00 : 2'b10;
      PERM_ALL_RO:  rw = 2'b10;
      default:      rw = 2'b00;
    endcase
    return rw;
  endfunction

  // Instruction permission: returns exec.
  function automatic logic instr_perm(input logic [3:0] p, input logic user);
    logic x;
    x = 1'b0;
    case (p) inside
      PERM_PRIV_RW, PERM_PRIV_RO:          x = !user;
      PERM_USER_RO, PERM_FULL, PERM_ALL_RO: x = 1'b1;
      default:                             x = 1'b0;
    endcase
    return x;
  endfunction

endpackage

FILE: design/cp15mpu_ifs.sv
// Valid/ready channel interfaces for the request and result beats.
// Depends on nothing; field widths follow the block's port list.
interface cp15mpu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] reg_code;
  logic [31:0] write_value;
  logic [31:0] access_address;
  logic        user_mode;

  modport source (output valid, req_type, reg_code, write_value, access_address,
                  user_mode, input ready);
  modport sink (input valid, req_type, reg_code, write_value, access_address,
                user_mode, output ready);
endinterface

interface cp15mpu_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        allow_read;
  logic        allow_write;
  logic        allow_exec;
  logic        data_cacheable;
  logic        instr_cacheable;
  logic        bufferable;
  logic        halt_request;
  logic        refused;

  modport source (output valid, read_data, allow_read, allow_write, allow_exec,
                  data_cacheable, instr_cacheable, bufferable, halt_request,
                  refused, input ready);
  modport sink (input valid, read_data, allow_read, allow_write, allow_exec,
                data_cacheable, instr_cacheable, bufferable, halt_request,
                refused, output ready);
endinterface

FILE: design/cp15_mpu_protection_unit_top.sv
// Top level of the coprocessor register file and protection unit.
// Depends on cp15mpu_pkg, cp15mpu_ifs and cp15mpu_region_cell.
//
// The block takes one request beat at a time. A register write or read puts
// its result in the result register when it is accepted; the result moves to
// the output register once that register is free, and from then on the next
// request can be accepted. An address lookup walks one region cell per cycle
// along a chain of NUM_REGIONS cells, each registering the token; its result
// then takes the same path through the result and output registers. The
// output register lets a new request be accepted while the previous result
// still waits downstream. Writes take effect when the write is accepted;
// halt_request is a single result beat flag, not a level.
module cp15_mpu_protection_unit_top #(
  parameter int NUM_REGIONS = cp15mpu_pkg::NUM_REGIONS_DEFAULT
) (
  input logic           clk,
  input logic           rst_n,
  cp15mpu_in_if.sink    in_bus,
  cp15mpu_out_if.source out_bus
);
  import cp15mpu_pkg::*;
  `include "assert_macros.svh"

  localparam logic [3:0] REGION_CNT = 4'(NUM_REGIONS);

  mpu_state_t  state_r, state_nxt;
  mpu_result_t res_r, res_nxt;
  mpu_result_t out_r;
  logic        out_valid_r;

  logic [31:0] ctrl_r, dcache_r, icache_r, buf_r, dperm_r, iperm_r, pid_r;
  logic [31:0] lock_r [2];
  logic [31:0] tcm_r [2];

  lookup_tok_t tok [NUM_REGIONS+1];
  logic [31:0] region_word [REGION_MAX];
  logic [REGION_MAX-1:0] region_wr;
  logic [NUM_REGIONS-1:0] tok_vld;

  logic        accept;
  logic        out_load;
  logic        is_region;
  logic [REGION_IDX_W-1:0] region_sel;
  logic        wr_fire;
  logic        wr_known;
  logic        wr_halt;
  logic        rd_known;
  logic [31:0] rd_data;
  logic [31:0] wv;
  logic [15:0] code;
  mpu_result_t reg_res;
  mpu_result_t look_res;
  logic [3:0]  dp, ip;
  logic [1:0]  drw;

  assign accept   = in_bus.valid && in_bus.ready;
  assign out_load = (state_r == ST_HOLD) && (!out_valid_r || out_bus.ready);
  assign code     = in_bus.reg_code;
  assign wv       = in_bus.write_value;

  // Region register codes are 0x06n0 and 0x06n1 with n below the region count.
  assign is_region  = (code[15:8] == CODE_REGION_HI) && (code[3:1] == 3'b000) &&
                      (code[7:4] < REGION_CNT);
  assign region_sel = code[4 +: REGION_IDX_W];
  assign wr_fire    = accept && (in_bus.req_type == REQ_WRITE) && !in_bus.user_mode;

  // Write decode: which codes are known and which raise a halt.
  always_comb begin
    wr_known = 1'b1;
    wr_halt  = 1'b0;
    if (!is_region) begin
      unique case (code) inside
        CODE_CTRL, CODE_DCACHE, CODE_ICACHE, CODE_BUFFER,
        CODE_DPERM_OLD, CODE_IPERM_OLD, CODE_DPERM, CODE_IPERM,
        CODE_DLOCK, CODE_ILOCK, CODE_DTCM, CODE_ITCM,
        CODE_PID_A, CODE_PID_B: wr_known = 1'b1;
        CODE_WFI_A, CODE_WFI_B: wr_halt = 1'b1;
        CODE_CM_0, CODE_CM_1, CODE_CM_2, CODE_CM_3,
        CODE_CM_4, CODE_CM_5, CODE_CM_6: wr_known = 1'b1;
        default: wr_known = 1'b0;
      endcase
    end
  end

  // Read decode.
  always_comb begin
    rd_known = 1'b1;
    rd_data  = '0;
    if (is_region) begin
      rd_data = region_word[region_sel];
    end else begin
      unique case (code) inside
        CODE_ID_MAIN0, CODE_ID_MAIN3, CODE_ID_MAIN4,
        CODE_ID_MAIN5, CODE_ID_MAIN6, CODE_ID_MAIN7: rd_data = ID_MAIN;
        CODE_ID_CACHE:  rd_data = ID_CACHE_TYPE;
        CODE_ID_TCM:    rd_data = ID_TCM_SIZE;
        CODE_CTRL:      rd_data = ctrl_r;
        CODE_DCACHE:    rd_data = dcache_r;
        CODE_ICACHE:    rd_data = icache_r;
        CODE_BUFFER:    rd_data = buf_r;
        CODE_DPERM_OLD: rd_data = narrow_nibbles(dperm_r);
        CODE_IPERM_OLD: rd_data = narrow_nibbles(iperm_r);
        CODE_DPERM:     rd_data = dperm_r;
        CODE_IPERM:     rd_data = iperm_r;
        CODE_DLOCK:     rd_data = lock_r[0];
        CODE_ILOCK:     rd_data = lock_r[1];
        CODE_DTCM:      rd_data = tcm_r[0];
        CODE_ITCM:      rd_data = tcm_r[1];
        CODE_PID_A, CODE_PID_B: rd_data = pid_r;
        default:        rd_known = 1'b0;
      endcase
    end
  end

  // Result of a register access or an unknown request type.
  always_comb begin
    reg_res = '0;
    unique case (in_bus.req_type)
      REQ_WRITE: begin
        reg_res.refused      = in_bus.user_mode || !wr_known;
        reg_res.halt_request = !in_bus.user_mode && wr_halt;
      end
      REQ_READ: begin
        reg_res.refused = in_bus.user_mode || !rd_known;
        if (!reg_res.refused) begin
          reg_res.read_data = rd_data;
        end
      end
      default: reg_res.refused = 1'b1;
    endcase
  end

  // Result of a lookup once the token leaves the last cell.
  always_comb begin
    look_res = '0;
    dp  = dperm_r[4*tok[NUM_REGIONS].idx +: 4];
    ip  = iperm_r[4*tok[NUM_REGIONS].idx +: 4];
    drw = data_perm(dp, tok[NUM_REGIONS].user);
    if (!ctrl_r[0]) begin
      look_res.allow_read  = 1'b1;
      look_res.allow_write = 1'b1;
      look_res.allow_exec  = 1'b1;
    end else if (tok[NUM_REGIONS].hit) begin
      look_res.allow_read      = drw[1];
      look_res.allow_write     = drw[0];
      look_res.allow_exec      = instr_perm(ip, tok[NUM_REGIONS].user);
      look_res.data_cacheable  = ctrl_r[2] && dcache_r[tok[NUM_REGIONS].idx];
      look_res.instr_cacheable = ctrl_r[12] && icache_r[tok[NUM_REGIONS].idx];
      look_res.bufferable      = buf_r[tok[NUM_REGIONS].idx];
    end
  end

  // Inject a lookup token into the first cell.
  always_comb begin
    tok[0].valid = accept && (in_bus.req_type == REQ_LOOKUP);
    tok[0].user  = in_bus.user_mode;
    tok[0].addr  = in_bus.access_address;
    tok[0].hit   = 1'b0;
    tok[0].idx   = '0;
  end

  // Region write strobes.
  always_comb begin
    region_wr = '0;
    if (wr_fire && is_region) begin
      region_wr[region_sel] = 1'b1;
    end
  end

  // Chain of region cells.
  for (genvar g = 0; g < REGION_MAX; g++) begin : g_region
    if (g < NUM_REGIONS) begin : g_cell
      cp15mpu_region_cell #(
        .INDEX(g)
      ) u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (region_wr[g]),
        .wr_data(wv & REGION_WRITE_MASK),
        .tok_i  (tok[g]),
        .tok_o  (tok[g+1]),
        .word_o (region_word[g])
      );
      assign tok_vld[g] = tok[g+1].valid;
    end else begin : g_absent
      assign region_word[g] = '0;
    end
  end

  // Request sequencer.
  always_comb begin
    state_nxt    = state_r;
    res_nxt      = res_r;
    in_bus.ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_bus.ready = 1'b1;
        if (accept) begin
          if (in_bus.req_type == REQ_LOOKUP) begin
            state_nxt = ST_WALK;
          end else begin
            res_nxt   = reg_res;
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_WALK: begin
        if (tok[NUM_REGIONS].valid) begin
          res_nxt   = look_res;
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    res_r <= res_nxt;
  end

  // Coprocessor register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r   <= '0;
      dcache_r <= '0;
      icache_r <= '0;
      buf_r    <= '0;
      dperm_r  <= '0;
      iperm_r  <= '0;
      pid_r    <= '0;
      lock_r   <= '{default: '0};
      tcm_r    <= '{default: '0};
    end else if (wr_fire && !is_region) begin
      case (code)
        CODE_CTRL:      ctrl_r <= (ctrl_r & ~CTRL_WRITE_MASK) | (wv & CTRL_WRITE_MASK);
        CODE_DCACHE:    dcache_r <= wv;
        CODE_ICACHE:    icache_r <= wv;
        CODE_BUFFER:    buf_r <= wv;
        CODE_DPERM_OLD: dperm_r <= widen_pairs(wv);
        CODE_IPERM_OLD: iperm_r <= widen_pairs(wv);
        CODE_DPERM:     dperm_r <= wv;
        CODE_IPERM:     iperm_r <= wv;
        CODE_DLOCK:     lock_r[0] <= wv & LOCK_WRITE_MASK;
        CODE_ILOCK:     lock_r[1] <= wv & LOCK_WRITE_MASK;
        CODE_DTCM:      tcm_r[0] <= wv & TCM_WRITE_MASK;
        CODE_ITCM:      tcm_r[1] <= wv & TCM_WRITE_MASK;
        CODE_PID_A:     pid_r <= wv;
        CODE_PID_B:     pid_r <= wv;
        default:        pid_r <= pid_r;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_r <= res_r;
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.read_data       = out_r.read_data;
  assign out_bus.allow_read      = out_r.allow_read;
  assign out_bus.allow_write     = out_r.allow_write;
  assign out_bus.allow_exec      = out_r.allow_exec;
  assign out_bus.data_cacheable  = out_r.data_cacheable;
  assign out_bus.instr_cacheable = out_r.instr_cacheable;
  assign out_bus.bufferable      = out_r.bufferable;
  assign out_bus.halt_request    = out_r.halt_request;
  assign out_bus.refused         = out_r.refused;

  // Only one lookup may be in the chain, and it must finish while walking.
  `MPU_ASSERT_NOW(a_one_token, 1'b1, $countones(tok_vld) <= 1, "two lookups in chain")
  `MPU_ASSERT_NOW(a_token_walk, tok[NUM_REGIONS].valid, state_r == ST_WALK,
                  "lookup left chain outside walk state")
  `MPU_ASSERT_NOW(a_hold_empty, state_r == ST_HOLD, tok_vld == '0,
                  "chain busy while result is held")
  `MPU_ASSERT_NEXT(a_out_load, out_load, out_valid_r && state_r == ST_IDLE,
                   "held result not moved to output")

endmodule

FILE: design/cp15mpu_region_cell.sv
// One protection region: holds its region word and checks a passing lookup.
// Depends on cp15mpu_pkg for the lookup token and masks.
module cp15mpu_region_cell #(
  parameter int INDEX = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     wr_en,
  input  logic [31:0]              wr_data,
  input  cp15mpu_pkg::lookup_tok_t tok_i,
  output cp15mpu_pkg::lookup_tok_t tok_o,
  output logic [31:0]              word_o
);
  import cp15mpu_pkg::*;

  logic [31:0] word_r;
  lookup_tok_t tok_r;
  lookup_tok_t tok_nxt;
  logic [5:0]  size;
  logic [31:0] mask;
  logic        match;

  // Region size is 2^(field+1) bytes, never below 4 KiB.
  always_comb begin
    size = {1'b0, word_r[5:1]} + 6'd1;
    if (size < 6'd12) begin
      size = 6'd12;
    end
    mask  = (size >= 6'd32) ? '0 : (ALL_ONES << size[4:0]);
    match = word_r[0] && ((tok_i.addr & mask) == (word_r & REGION_BASE_MASK));
  end

  // A later cell overrides, so the highest matching region wins.
  always_comb begin
    tok_nxt = tok_i;
    if (match) begin
      tok_nxt.hit = 1'b1;
      tok_nxt.idx = REGION_IDX_W'(INDEX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r      <= '0;
      tok_r.valid <= 1'b0;
    end else begin
      if (wr_en) begin
        word_r <= wr_data;
      end
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.user <= tok_nxt.user;
    tok_r.addr <= tok_nxt.addr;
    tok_r.hit  <= tok_nxt.hit;
    tok_r.idx  <= tok_nxt.idx;
  end

  assign tok_o  = tok_r;
  assign word_o = word_r;

endmodule

FILE: bench/cp15_mpu_protection_unit_top_tb.sv
// Self-checking bench for the coprocessor register file and protection unit.
// Depends on cp15mpu_pkg, the channel interfaces in cp15mpu_ifs.sv and the top level.
// A local register-file mirror predicts each result beat; stimulus is directed, then random.
module cp15_mpu_protection_unit_top_tb;
  import cp15mpu_pkg::*;

  localparam int REGION_COUNT   = 8;
  localparam int WATCHDOG_LIMIT = 4000;

  // Register codes used by the random register traffic.
  localparam logic [15:0] READ_CODES [24] = '{
    CODE_ID_MAIN0, CODE_ID_CACHE, CODE_ID_TCM, CODE_ID_MAIN3, CODE_ID_MAIN4,
    CODE_ID_MAIN5, CODE_ID_MAIN6, CODE_ID_MAIN7, CODE_CTRL, CODE_DCACHE,
    CODE_ICACHE, CODE_BUFFER, CODE_DPERM_OLD, CODE_IPERM_OLD, CODE_DPERM,
    CODE_IPERM, CODE_DLOCK, CODE_ILOCK, CODE_DTCM, CODE_ITCM, CODE_PID_A,
    CODE_PID_B, CODE_WFI_A, CODE_CM_4
  };
  localparam logic [15:0] MISC_WRITE_CODES [16] = '{
    CODE_DLOCK, CODE_ILOCK, CODE_DTCM, CODE_ITCM, CODE_PID_A, CODE_PID_B,
    CODE_WFI_A, CODE_WFI_B, CODE_CM_0, CODE_CM_1, CODE_CM_2, CODE_CM_3,
    CODE_CM_4, CODE_CM_5, CODE_CM_6, CODE_ID_MAIN0
  };

  // One request as the bench keeps it.
  typedef struct {
    req_type_t   kind;
    logic [15:0] code;
    logic [31:0] wdata;
    logic [31:0] addr;
    logic        user;
  } cp_req_t;

  logic clk = 1'b0;
  logic rst_n;

  cp15mpu_in_if  req_ch ();
  cp15mpu_out_if res_ch ();

  cp15_mpu_protection_unit_top #(
    .NUM_REGIONS(REGION_COUNT)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (req_ch),
    .out_bus(res_ch)
  );

  always #4 clk = ~clk;

  // Mirror of the register file.
  logic [31:0] ctrl_q;
  logic [31:0] dcache_bits;
  logic [31:0] icache_bits;
  logic [31:0] wbuf_bits;
  logic [31:0] dperm_q;
  logic [31:0] iperm_q;
  logic [31:0] pid_q;
  logic [31:0] rgn_q [REGION_COUNT];
  logic [31:0] lock_q [2];
  logic [31:0] tcm_q [2];

  mpu_result_t pending_q [$];
  int          err_cnt = 0;
  int          idle_cycles = 0;
  bit          src_gaps = 1'b1;
  bit          snk_gaps = 1'b1;

  // Spread 2-bit legacy permission pairs into nibbles, and back.
  function automatic logic [31:0] spread_pairs(input logic [31:0] v);
    logic [31:0] r;
    r = '0;
    for (int k = 0; k < 8; k++) begin
      r[4*k]   = v[2*k];
      r[4*k+1] = v[2*k+1];
    end
    return r;
  endfunction

  function automatic logic [31:0] gather_pairs(input logic [31:0] v);
    logic [31:0] r;
    r = '0;
    for (int k = 0; k < 8; k++) begin
      r[2*k]   = v[4*k];
      r[2*k+1] = v[4*k+1];
    end
    return r;
  endfunction

  // Region number for a region register code, or -1.
  function automatic int region_index(input logic [15:0] code);
    if (code[15:8] != CODE_REGION_HI || code[3:1] != 3'b000 ||
        int'(code[7:4]) >= REGION_COUNT) begin
      return -1;
    end
    return int'(code[7:4]);
  endfunction

  // Applies a privileged write; returns 0 for a code that does not exist.
  function automatic bit store_write(input logic [15:0] code, input logic [31:0] v,
                                     output logic halt);
    int idx;
    halt = 1'b0;
    idx = region_index(code);
    if (idx >= 0) begin
      rgn_q[idx] = v & REGION_WRITE_MASK;
      return 1'b1;
    end
    case (code)
      CODE_CTRL:      ctrl_q = (ctrl_q & ~CTRL_WRITE_MASK) | (v & CTRL_WRITE_MASK);
      CODE_DCACHE:    dcache_bits = v;
      CODE_ICACHE:    icache_bits = v;
      CODE_BUFFER:    wbuf_bits = v;
      CODE_DPERM_OLD: dperm_q = spread_pairs(v);
      CODE_IPERM_OLD: iperm_q = spread_pairs(v);
      CODE_DPERM:     dperm_q = v;
      CODE_IPERM:     iperm_q = v;
      CODE_WFI_A, CODE_WFI_B: halt = 1'b1;
      CODE_CM_0, CODE_CM_1, CODE_CM_2, CODE_CM_3, CODE_CM_4, CODE_CM_5,
      CODE_CM_6: begin
      end
      CODE_DLOCK:     lock_q[0] = v & LOCK_WRITE_MASK;
      CODE_ILOCK:     lock_q[1] = v & LOCK_WRITE_MASK;
      CODE_DTCM:      tcm_q[0] = v & TCM_WRITE_MASK;
      CODE_ITCM:      tcm_q[1] = v & TCM_WRITE_MASK;
      CODE_PID_A, CODE_PID_B: pid_q = v;
      default:        return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Privileged read; returns 0 for a code that cannot be read.
  function automatic bit fetch_reg(input logic [15:0] code, output logic [31:0] data);
    int idx;
    data = '0;
    idx = region_index(code);
    if (idx >= 0) begin
      data = rgn_q[idx];
      return 1'b1;
    end
    case (code)
      CODE_ID_MAIN0, CODE_ID_MAIN3, CODE_ID_MAIN4, CODE_ID_MAIN5, CODE_ID_MAIN6,
      CODE_ID_MAIN7:  data = ID_MAIN;
      CODE_ID_CACHE:  data = ID_CACHE_TYPE;
      CODE_ID_TCM:    data = ID_TCM_SIZE;
      CODE_CTRL:      data = ctrl_q;
      CODE_DCACHE:    data = dcache_bits;
      CODE_ICACHE:    data = icache_bits;
      CODE_BUFFER:    data = wbuf_bits;
      CODE_DPERM_OLD: data = gather_pairs(dperm_q);
      CODE_IPERM_OLD: data = gather_pairs(iperm_q);
      CODE_DPERM:     data = dperm_q;
      CODE_IPERM:     data = iperm_q;
      CODE_DLOCK:     data = lock_q[0];
      CODE_ILOCK:     data = lock_q[1];
      CODE_DTCM:      data = tcm_q[0];
      CODE_ITCM:      data = tcm_q[1];
      CODE_PID_A, CODE_PID_B: data = pid_q;
      default:        return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Address mask of a region word; zero when the region spans everything.
  function automatic logic [31:0] region_keep(input logic [31:0] w);
    int span;
    span = int'(w[5:1]) + 1;
    if (span < 12) span = 12;
    return (span >= 32) ? '0 : (ALL_ONES << span);
  endfunction

  // Permission lookup: the highest enabled matching region decides.
  function automatic mpu_result_t judge_address(input logic [31:0] addr, input logic user);
    mpu_result_t res;
    int          hit;
    logic [3:0]  dnib;
    logic [3:0]  inib;
    res = '0;
    hit = -1;
    if (!ctrl_q[0]) begin
      res.allow_read  = 1'b1;
      res.allow_write = 1'b1;
      res.allow_exec  = 1'b1;
      return res;
    end
    for (int i = 0; i < REGION_COUNT; i++) begin
      if (rgn_q[i][0] && ((addr & region_keep(rgn_q[i])) == (rgn_q[i] & REGION_BASE_MASK)))
        hit = i;
    end
    if (hit < 0) return res;
    dnib = dperm_q[4*hit +: 4];
    inib = iperm_q[4*hit +: 4];
    case (dnib)
      PERM_PRIV_RW: begin
        res.allow_read  = !user;
        res.allow_write = !user;
      end
      PERM_USER_RO: begin
        res.allow_read  = 1'b1;
        res.allow_write = !user;
      end
      PERM_FULL: begin
        res.allow_read  = 1'b1;
        res.allow_write = 1'b1;
      end
      PERM_PRIV_RO: res.allow_read = !user;
      PERM_ALL_RO:  res.allow_read = 1'b1;
      default: begin
      end
    endcase
    case (inib)
      PERM_PRIV_RW, PERM_PRIV_RO:           res.allow_exec = !user;
      PERM_USER_RO, PERM_FULL, PERM_ALL_RO: res.allow_exec = 1'b1;
      default: begin
      end
    endcase
    res.data_cacheable  = ctrl_q[2] & dcache_bits[hit];
    res.instr_cacheable = ctrl_q[12] & icache_bits[hit];
    res.bufferable      = wbuf_bits[hit];
    return res;
  endfunction

  // Expected result beat of one accepted request; updates the mirror.
  function automatic mpu_result_t predict_beat(input cp_req_t q);
    mpu_result_t res;
    logic        halt;
    logic [31:0] rd;
    res = '0;
    case (q.kind)
      REQ_WRITE: begin
        if (q.user) begin
          res.refused = 1'b1;
        end else begin
          res.refused      = !store_write(q.code, q.wdata, halt);
          res.halt_request = halt;
        end
      end
      REQ_READ: begin
        if (q.user || !fetch_reg(q.code, rd)) res.refused = 1'b1;
        else res.read_data = rd;
      end
      REQ_LOOKUP: res = judge_address(q.addr, q.user);
      default: res.refused = 1'b1;
    endcase
    return res;
  endfunction

  // Drives one request beat and records its expected result once accepted.
  task automatic send_beat(input cp_req_t q);
    while (src_gaps && $urandom_range(99) < 15) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.req_type       <= q.kind;
    req_ch.reg_code       <= q.code;
    req_ch.write_value    <= q.wdata;
    req_ch.access_address <= q.addr;
    req_ch.user_mode      <= q.user;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_q.push_back(predict_beat(q));
  endtask

  task automatic put_reg(input logic [15:0] code, input logic [31:0] v, input logic user = 1'b0);
    cp_req_t q;
    q = '{kind: REQ_WRITE, code: code, wdata: v, addr: $urandom, user: user};
    send_beat(q);
  endtask

  task automatic get_reg(input logic [15:0] code, input logic user = 1'b0);
    cp_req_t q;
    q = '{kind: REQ_READ, code: code, wdata: $urandom, addr: $urandom, user: user};
    send_beat(q);
  endtask

  task automatic probe_addr(input logic [31:0] addr, input logic user);
    cp_req_t q;
    q = '{kind: REQ_LOOKUP, code: 16'($urandom), wdata: $urandom, addr: addr, user: user};
    send_beat(q);
  endtask

  // Holds the request side quiet until every expected beat has arrived.
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // Random region word: mostly aligned bases, some arbitrary words.
  function automatic logic [31:0] make_region_word();
    logic [31:0] w;
    int          s;
    s = $urandom_range(31);
    w = 32'(s) << 1;
    w = ($urandom & region_keep(w) & REGION_BASE_MASK) | w | ($urandom & 32'h0000_0FC0);
    w[0] = ($urandom_range(99) < 85);
    if ($urandom_range(4) == 0) w = $urandom;
    return w;
  endfunction

  // Permission word made mostly of meaningful nibble codes.
  function automatic logic [31:0] make_perm_word();
    logic [31:0] w;
    w = '0;
    for (int k = 0; k < 8; k++) begin
      case ($urandom_range(5))
        0:       w[4*k +: 4] = PERM_PRIV_RW;
        1:       w[4*k +: 4] = PERM_USER_RO;
        2:       w[4*k +: 4] = PERM_FULL;
        3:       w[4*k +: 4] = PERM_PRIV_RO;
        4:       w[4*k +: 4] = PERM_ALL_RO;
        default: w[4*k +: 4] = 4'($urandom);
      endcase
    end
    return w;
  endfunction

  // Address inside a random region, taken from its current word.
  function automatic logic [31:0] aim_address();
    logic [31:0] w;
    logic [31:0] keep;
    w = rgn_q[$urandom_range(REGION_COUNT - 1)];
    keep = region_keep(w);
    return (w & REGION_BASE_MASK & keep) | ($urandom & ~keep);
  endfunction

  // ID registers, user-mode refusal and lookup with the MPU off after reset.
  task automatic test_reset_state();
    get_reg(CODE_ID_MAIN0);
    get_reg(CODE_ID_CACHE);
    get_reg(CODE_ID_TCM);
    get_reg(CODE_ID_MAIN7, 1'b1);
    probe_addr(ALL_ONES, 1'b1);
  endtask

  // Write masks, legacy permissions, wait for interrupt and unknown codes.
  task automatic test_register_access();
    put_reg(CODE_CTRL, ALL_ONES);
    get_reg(CODE_CTRL);
    put_reg(CODE_DPERM_OLD, 32'hFFFF_5555);
    get_reg(CODE_DPERM_OLD);
    put_reg(CODE_WFI_A, '0);
    put_reg(CODE_WFI_B, '0, 1'b1);
    put_reg(CODE_ID_MAIN0, ALL_ONES);
    get_reg(CODE_CM_0);
    put_reg({CODE_REGION_HI, 4'd8, 3'b000, 1'b1}, ALL_ONES);
  endtask

  // Whole-space, small, disabled and misaligned regions; highest region wins.
  task automatic test_region_match();
    put_reg({CODE_REGION_HI, 4'd0, 3'b000, 1'b0}, 32'h0000_003F);
    put_reg({CODE_REGION_HI, 4'd1, 3'b000, 1'b1}, 32'h0000_1001);
    put_reg({CODE_REGION_HI, 4'd2, 3'b000, 1'b0}, 32'h0000_1000);
    put_reg({CODE_REGION_HI, 4'd7, 3'b000, 1'b0}, ALL_ONES);
    put_reg(CODE_DPERM, 32'h0000_0613);
    put_reg(CODE_IPERM, 32'h0000_0052);
    put_reg(CODE_DCACHE, 32'h0000_0003);
    probe_addr(32'h0000_1000, 1'b0);
    probe_addr(32'h0000_1FFF, 1'b1);
    probe_addr(ALL_ONES, 1'b0);
    probe_addr(32'h0000_0000, 1'b1);
  endtask

  // Mixed traffic: region setup, permission and cache writes, reads, noise
  // and mostly lookups aimed at programmed regions.
  task automatic test_random_traffic(input int total);
    int          sent;
    int          pick;
    logic [31:0] v;
    logic        usr;
    cp_req_t     q;
    sent = 0;
    while (sent < total) begin
      src_gaps = !(sent >= total / 3 && sent < total / 2);
      snk_gaps = src_gaps;
      if (sent == total / 2 || $urandom_range(149) == 0) drain_results();
      usr  = ($urandom_range(7) == 0);
      pick = $urandom_range(99);
      if (pick < 12) begin
        put_reg({CODE_REGION_HI, 1'b0, 3'($urandom), 3'b000, 1'($urandom)},
                make_region_word());
      end else if (pick < 18) begin
        case ($urandom_range(3))
          0:       put_reg(CODE_DPERM, make_perm_word(), usr);
          1:       put_reg(CODE_IPERM, make_perm_word(), usr);
          2:       put_reg(CODE_DPERM_OLD, $urandom, usr);
          default: put_reg(CODE_IPERM_OLD, $urandom, usr);
        endcase
      end else if (pick < 23) begin
        v = $urandom;
        case ($urandom_range(3))
          0: put_reg(CODE_DCACHE, v, usr);
          1: put_reg(CODE_ICACHE, v, usr);
          2: put_reg(CODE_BUFFER, v, usr);
          default: begin
            if ($urandom_range(4) != 0) v[0] = 1'b1;
            put_reg(CODE_CTRL, v, usr);
          end
        endcase
      end else if (pick < 31) begin
        if ($urandom_range(9) < 7) get_reg(READ_CODES[$urandom_range(23)], usr);
        else get_reg({CODE_REGION_HI, 4'($urandom), 1'b0, 3'($urandom)}, usr);
      end else if (pick < 37) begin
        put_reg(MISC_WRITE_CODES[$urandom_range(15)], $urandom, usr);
      end else if (pick < 41) begin
        // Any request type, including the unused encoding.
        q = '{kind: req_type_t'($urandom_range(3)), code: 16'($urandom),
              wdata: $urandom, addr: $urandom, user: 1'($urandom)};
        send_beat(q);
      end else begin
        probe_addr(($urandom_range(9) < 7) ? aim_address() : $urandom, 1'($urandom));
      end
      sent++;
    end
    src_gaps = 1'b1;
    snk_gaps = 1'b1;
  endtask

  task automatic match_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
    end
  endtask

  // Result side stalls at random.
  always @(posedge clk) begin
    if (!rst_n) res_ch.ready <= 1'b0;
    else res_ch.ready <= !(snk_gaps && $urandom_range(99) < 15);
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin : result_check
    mpu_result_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_q.size() == 0) begin
        err_cnt++;
        $display("%0t: result beat with none expected, read_data %h refused %b",
                 $time, res_ch.read_data, res_ch.refused);
      end else begin
        want = pending_q.pop_front();
        match_field("read_data", want.read_data, res_ch.read_data);
        match_field("allow_read", 32'(want.allow_read), 32'(res_ch.allow_read));
        match_field("allow_write", 32'(want.allow_write), 32'(res_ch.allow_write));
        match_field("allow_exec", 32'(want.allow_exec), 32'(res_ch.allow_exec));
        match_field("data_cacheable", 32'(want.data_cacheable), 32'(res_ch.data_cacheable));
        match_field("instr_cacheable", 32'(want.instr_cacheable),
                    32'(res_ch.instr_cacheable));
        match_field("bufferable", 32'(want.bufferable), 32'(res_ch.bufferable));
        match_field("halt_request", 32'(want.halt_request), 32'(res_ch.halt_request));
        match_field("refused", 32'(want.refused), 32'(res_ch.refused));
      end
    end
  end

  // Watchdog on cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    rst_n                 <= 1'b0;
    req_ch.valid          <= 1'b0;
    req_ch.req_type       <= REQ_WRITE;
    req_ch.reg_code       <= '0;
    req_ch.write_value    <= '0;
    req_ch.access_address <= '0;
    req_ch.user_mode      <= 1'b0;
    ctrl_q      = '0;
    dcache_bits = '0;
    icache_bits = '0;
    wbuf_bits   = '0;
    dperm_q     = '0;
    iperm_q     = '0;
    pid_q       = '0;
    for (int i = 0; i < REGION_COUNT; i++) rgn_q[i] = '0;
    lock_q = '{default: '0};
    tcm_q  = '{default: '0};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_register_access();
    test_region_match();
    drain_results();
    test_random_traffic(800);

    drain_results();
    repeat (REGION_COUNT + 8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
